@@ rtl/lcdfb_pkg.sv @@
// Shared constants, font table and control types for the LCD text/pixel frame store.
// Used by lcdfb_ctrl, lcdfb_dp, the top and the testbench; no dependencies.
package lcdfb_pkg;

    localparam int COLUMNS_DEF  = 84;
    localparam int BANKS_DEF    = 6;
    localparam int GLYPH_WIDTH  = 5;
    localparam int CELL_WIDTH   = GLYPH_WIDTH + 1;
    localparam int CHAR_FIRST   = 32'h20;
    localparam int CHAR_LAST    = 32'h7f;
    localparam logic [7:0] ROW_CMD_BASE = 8'h40;
    localparam logic [7:0] COL_CMD_BASE = 8'h80;

    localparam logic [2:0] FUNC_CLEAR   = 3'd0;
    localparam logic [2:0] FUNC_PUTCHAR = 3'd1;
    localparam logic [2:0] FUNC_TEXTPOS = 3'd2;
    localparam logic [2:0] FUNC_PIXON   = 3'd3;
    localparam logic [2:0] FUNC_PIXOFF  = 3'd4;
    localparam logic [2:0] FUNC_READ    = 3'd5;

    // One row per glyph, first column byte in the top bits.
    localparam logic [39:0] GLYPH_ROM [96] = '{
        40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
        40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
        40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414147c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
        40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
    };

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_EXEC   = 8'b0000_0100,
        ST_SWEEP  = 8'b0000_1000,
        ST_GLYPH  = 8'b0001_0000,
        ST_PXWR   = 8'b0010_0000,
        ST_FINISH = 8'b0100_0000,
        ST_SPARE  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic cap;
        logic sweep;
        logic glyph;
        logic px_wr;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       req_ok;
        logic       sweep_last;
        logic       glyph_last;
        logic       out_busy;
    } dp_status_t;

endpackage

@@ rtl/lcdfb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcdfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 504
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/lcdfb_ctrl.sv @@
// Controller state machine: sequences sweeps, glyph writes, pixel read-modify-write.
// Depends on lcdfb_pkg.
module lcdfb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lcdfb_pkg::dp_status_t st,
    output lcdfb_pkg::dp_cmd_t   cmd
);
    lcdfb_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcdfb_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == lcdfb_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            lcdfb_pkg::ST_INIT: begin
                cmd.sweep = 1'b1;
                if (st.sweep_last) begin
                    state_next = lcdfb_pkg::ST_IDLE;
                end
            end
            lcdfb_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.cap    = 1'b1;
                    state_next = lcdfb_pkg::ST_EXEC;
                end
            end
            lcdfb_pkg::ST_EXEC: begin
                // read port already addressed from captured request
                state_next = lcdfb_pkg::ST_FINISH;
                if (st.req_ok) begin
                    case (st.func)
                        lcdfb_pkg::FUNC_CLEAR:   state_next = lcdfb_pkg::ST_SWEEP;
                        lcdfb_pkg::FUNC_PUTCHAR: state_next = lcdfb_pkg::ST_GLYPH;
                        lcdfb_pkg::FUNC_PIXON:   state_next = lcdfb_pkg::ST_PXWR;
                        lcdfb_pkg::FUNC_PIXOFF:  state_next = lcdfb_pkg::ST_PXWR;
                        default:                 state_next = lcdfb_pkg::ST_FINISH;
                    endcase
                end
            end
            lcdfb_pkg::ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (st.sweep_last) begin
                    state_next = lcdfb_pkg::ST_FINISH;
                end
            end
            lcdfb_pkg::ST_GLYPH: begin
                cmd.glyph = 1'b1;
                if (st.glyph_last) begin
                    state_next = lcdfb_pkg::ST_FINISH;
                end
            end
            lcdfb_pkg::ST_PXWR: begin
                cmd.px_wr  = 1'b1;
                state_next = lcdfb_pkg::ST_FINISH;
            end
            lcdfb_pkg::ST_FINISH: begin
                if (!st.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = lcdfb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lcdfb_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

@@ rtl/lcdfb_dp.sv @@
// Datapath: request registers, cursor, address generation, frame store, result register.
// Depends on lcdfb_pkg and lcdfb_ram.
module lcdfb_dp #(
    parameter int COLUMNS = lcdfb_pkg::COLUMNS_DEF,
    parameter int BANKS   = lcdfb_pkg::BANKS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [39:0]           s_tdata,
    output logic [39:0]           m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  lcdfb_pkg::dp_cmd_t    cmd,
    output lcdfb_pkg::dp_status_t st
);
    localparam int STORE = COLUMNS * BANKS;
    localparam int AW    = $clog2(STORE);
    localparam int BW    = $clog2(BANKS + 2);
    localparam int CW    = $clog2(COLUMNS + 2);
    localparam int LW    = $clog2((BANKS + 2) * COLUMNS);
    localparam int CELLS = COLUMNS / lcdfb_pkg::CELL_WIDTH;

    logic [2:0] func_reg;
    logic [7:0] code_reg, row_reg, col_reg;
    logic [8:0] idx_reg;

    logic [BW-1:0] bank_reg;
    logic [CW-1:0] ccol_reg;
    logic [AW-1:0] cnt_reg;
    logic [2:0]    gidx_reg;
    logic          out_valid_reg;
    logic [39:0]   out_reg;

    logic          wrap, txt_ok, px_ok, put_ok, rd_ok, req_ok;
    logic [BW-1:0] gbank, nbank, px_bank, bank_next;
    logic [CW-1:0] gcol, ncol6, ncol, cell_col, col_next;
    logic [LW-1:0] gpos, px_addr, cur_lin;
    logic [39:0]   glyph_row;
    logic [7:0]    glyph_byte, rdata, mask, px_byte;
    logic          ram_we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata;
    logic          cmd_ok;

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            func_reg <= s_tdata[2:0];
            code_reg <= s_tdata[10:3];
            row_reg  <= s_tdata[18:11];
            col_reg  <= s_tdata[26:19];
            idx_reg  <= s_tdata[35:27];
        end
    end

    // glyph start: next line when the glyph would cross the right edge
    assign wrap  = 32'(ccol_reg) > (COLUMNS - lcdfb_pkg::GLYPH_WIDTH);
    assign gbank = wrap ? BW'(bank_reg + 1'b1) : bank_reg;
    assign gcol  = wrap ? '0 : ccol_reg;
    assign gpos  = LW'(32'(gbank) * COLUMNS + 32'(gcol));
    assign ncol6 = CW'(gcol + CW'(lcdfb_pkg::CELL_WIDTH));
    assign nbank = (32'(ncol6) >= COLUMNS) ? BW'(gbank + 1'b1) : gbank;
    assign ncol  = (32'(ncol6) >= COLUMNS) ? CW'(32'(ncol6) - COLUMNS) : ncol6;

    assign px_bank  = BW'(row_reg >> 3);
    assign px_addr  = LW'(32'(px_bank) * COLUMNS + 32'(col_reg));
    assign cell_col = CW'(32'(col_reg) * lcdfb_pkg::CELL_WIDTH);

    assign txt_ok = (32'(row_reg) < BANKS) && (32'(col_reg) < CELLS);
    assign px_ok  = (32'(row_reg) < BANKS * 8) && (32'(col_reg) < COLUMNS);
    assign rd_ok  = 32'(idx_reg) < STORE;
    assign put_ok = (32'(code_reg) >= lcdfb_pkg::CHAR_FIRST)
                 && (32'(code_reg) <= lcdfb_pkg::CHAR_LAST)
                 && (32'(gpos) + lcdfb_pkg::GLYPH_WIDTH <= STORE);

    always_comb begin
        case (func_reg)
            lcdfb_pkg::FUNC_CLEAR:   req_ok = 1'b1;
            lcdfb_pkg::FUNC_PUTCHAR: req_ok = put_ok;
            lcdfb_pkg::FUNC_TEXTPOS: req_ok = txt_ok;
            lcdfb_pkg::FUNC_PIXON:   req_ok = px_ok;
            lcdfb_pkg::FUNC_PIXOFF:  req_ok = px_ok;
            lcdfb_pkg::FUNC_READ:    req_ok = rd_ok;
            default:                 req_ok = 1'b0;
        endcase
    end

    assign glyph_row  = lcdfb_pkg::GLYPH_ROM[7'(code_reg - 8'h20)];
    assign glyph_byte = glyph_row[8 * (4 - 32'(gidx_reg)) +: 8];
    assign mask       = 8'(1) << row_reg[2:0];
    assign px_byte    = (func_reg == lcdfb_pkg::FUNC_PIXON) ? (rdata | mask) : (rdata & ~mask);

    assign ram_we = cmd.sweep || cmd.glyph || cmd.px_wr;
    always_comb begin
        if (cmd.sweep) begin
            waddr = cnt_reg;
            wdata = '0;
        end else if (cmd.glyph) begin
            waddr = AW'(gpos + LW'(gidx_reg));
            wdata = glyph_byte;
        end else begin
            waddr = AW'(px_addr);
            wdata = px_byte;
        end
    end
    assign raddr = (func_reg == lcdfb_pkg::FUNC_READ) ? AW'(idx_reg) : AW'(px_addr);

    lcdfb_ram #(.WIDTH(8), .DEPTH(STORE)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.cap) begin
            cnt_reg  <= '0;
            gidx_reg <= '0;
        end else begin
            if (cmd.sweep) begin
                cnt_reg <= AW'(cnt_reg + 1'b1);
            end
            if (cmd.glyph) begin
                gidx_reg <= 3'(gidx_reg + 1'b1);
            end
        end
    end

    // cursor after the request
    always_comb begin
        bank_next = bank_reg;
        col_next  = ccol_reg;
        if (req_ok) begin
            case (func_reg)
                lcdfb_pkg::FUNC_PUTCHAR: begin
                    bank_next = nbank;
                    col_next  = ncol;
                end
                lcdfb_pkg::FUNC_TEXTPOS: begin
                    bank_next = BW'(row_reg);
                    col_next  = cell_col;
                end
                lcdfb_pkg::FUNC_PIXON, lcdfb_pkg::FUNC_PIXOFF: begin
                    bank_next = px_bank;
                    col_next  = CW'(col_reg);
                end
                default: begin
                    bank_next = bank_reg;
                end
            endcase
        end
    end
    assign cur_lin = LW'(32'(bank_next) * COLUMNS + 32'(col_next));
    assign cmd_ok  = req_ok && (func_reg == lcdfb_pkg::FUNC_TEXTPOS
                  || func_reg == lcdfb_pkg::FUNC_PIXON || func_reg == lcdfb_pkg::FUNC_PIXOFF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg      <= '0;
            ccol_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                bank_reg      <= bank_next;
                ccol_reg      <= col_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg[0]     <= req_ok;
            out_reg[8:1]   <= (req_ok && func_reg == lcdfb_pkg::FUNC_READ) ? rdata : 8'h00;
            out_reg[17:9]  <= 9'(32'(cur_lin));
            out_reg[18]    <= cmd_ok;
            out_reg[26:19] <= cmd_ok ? (lcdfb_pkg::ROW_CMD_BASE | 8'(bank_next)) : 8'h00;
            out_reg[34:27] <= cmd_ok ? (lcdfb_pkg::COL_CMD_BASE | 8'(col_next)) : 8'h00;
            out_reg[39:35] <= '0;
        end
    end

    assign m_tdata  = out_reg;
    assign m_tvalid = out_valid_reg;

    assign st.func       = func_reg;
    assign st.req_ok     = req_ok;
    assign st.sweep_last = (32'(cnt_reg) == STORE - 1);
    assign st.glyph_last = (32'(gidx_reg) == lcdfb_pkg::GLYPH_WIDTH - 1);
    assign st.out_busy   = out_valid_reg && !m_tready;
endmodule

@@ rtl/lcd_text_pixel_framebuffer_top.sv @@
// LCD text/pixel frame store.
// One request at a time; the store has separate write and read ports and writes one byte per cycle.
// Reset: synchronous active-low; cursor zeroed, then a clearing pass zeroes the store
// before the first request is taken.
// Depends on lcdfb_pkg, lcdfb_ctrl, lcdfb_dp, lcdfb_ram.
module lcd_text_pixel_framebuffer_top #(
    parameter int COLUMNS = lcdfb_pkg::COLUMNS_DEF,
    parameter int BANKS   = lcdfb_pkg::BANKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // func, char_code, row_coord, col_coord, byte_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // ok, read_data, cursor_out, commands_valid,
                                  // row_command, column_command
);
    lcdfb_pkg::dp_cmd_t    cmd;
    lcdfb_pkg::dp_status_t st;

    lcdfb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lcdfb_dp #(.COLUMNS(COLUMNS), .BANKS(BANKS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .st       (st)
    );
endmodule

@@ verif/testbench.sv @@
// Testbench for the LCD text/pixel frame store: directed and random requests,
// checked against an in-bench model of the store, cursor and font table.
// Depends on lcdfb_pkg and lcd_text_pixel_framebuffer_top.
`timescale 1ns / 1ps

module testbench;
    import lcdfb_pkg::*;

    localparam int NCOL  = COLUMNS_DEF;
    localparam int NBANK = BANKS_DEF;
    localparam int STORE = NCOL * NBANK;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [7:0] column_command;
        logic [7:0] row_command;
        logic       commands_valid;
        logic [8:0] cursor_out;
        logic [7:0] read_data;
        logic       ok;
    } fb_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    lcd_text_pixel_framebuffer_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [7:0] shadow_store [STORE];
    logic [8:0] shadow_cursor;
    fb_result_t expected_results [$];
    int errors = 0;
    int cycles = 0;
    bit rx_stall_on = 1'b1;

    // Model one request; returns its result and updates the shadow state.
    function automatic fb_result_t model_request(logic [2:0] func, logic [7:0] code,
                                                 logic [7:0] row, logic [7:0] col,
                                                 logic [8:0] idx);
        fb_result_t r;
        int pos, addr;
        logic [39:0] g;
        r = '0;
        case (func)
            FUNC_CLEAR: begin
                for (int i = 0; i < STORE; i++) shadow_store[i] = 8'h00;
                r.ok = 1'b1;
            end
            FUNC_PUTCHAR: begin
                pos = shadow_cursor;
                if (code >= CHAR_FIRST && code <= CHAR_LAST) begin
                    if (pos % NCOL > NCOL - GLYPH_WIDTH) pos = (pos / NCOL + 1) * NCOL;
                    if (pos + GLYPH_WIDTH <= STORE) begin
                        g = GLYPH_ROM[code - CHAR_FIRST];
                        for (int i = 0; i < GLYPH_WIDTH; i++)
                            shadow_store[pos + i] = g[39 - 8*i -: 8];
                        shadow_cursor = pos + CELL_WIDTH;
                        r.ok = 1'b1;
                    end
                end
            end
            FUNC_TEXTPOS: begin
                if (row < NBANK && col < NCOL / CELL_WIDTH) begin
                    r.ok = 1'b1;
                    r.commands_valid = 1'b1;
                    r.row_command = ROW_CMD_BASE | row;
                    r.column_command = COL_CMD_BASE | 8'(col * CELL_WIDTH);
                    shadow_cursor = row * NCOL + col * CELL_WIDTH;
                end
            end
            FUNC_PIXON, FUNC_PIXOFF: begin
                if (row < NBANK * 8 && col < NCOL) begin
                    addr = (row / 8) * NCOL + col;
                    r.ok = 1'b1;
                    r.commands_valid = 1'b1;
                    r.row_command = ROW_CMD_BASE | 8'(row / 8);
                    r.column_command = COL_CMD_BASE | col;
                    shadow_cursor = addr;
                    shadow_store[addr][row % 8] = (func == FUNC_PIXON);
                end
            end
            FUNC_READ: begin
                if (idx < STORE) begin
                    r.ok = 1'b1;
                    r.read_data = shadow_store[idx];
                end
            end
            default: ;
        endcase
        r.cursor_out = shadow_cursor;
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The block is busy in its execute and finish states after taking a request,
    // so the idle wait before the next request costs nothing.
    task automatic send_request(logic [2:0] func, logic [7:0] code, logic [7:0] row,
                                logic [7:0] col, logic [8:0] idx, bit gaps = 1'b1);
        int g;
        g = gaps ? gap_len() : 0;
        repeat (g + 1) @(negedge aclk);
        expected_results.push_back(model_request(func, code, row, col, idx));
        s_tdata <= {1'b0, idx, col, row, code, func};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // Result checker
    always @(posedge aclk) begin
        fb_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = fb_result_t'(m_tdata[34:0]);
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.ok !== want.ok) begin
                    $error("ok exp %0d got %0d", want.ok, got.ok); errors++;
                end
                if (got.read_data !== want.read_data) begin
                    $error("read_data exp %h got %h", want.read_data, got.read_data);
                    errors++;
                end
                if (got.cursor_out !== want.cursor_out) begin
                    $error("cursor_out exp %0d got %0d", want.cursor_out, got.cursor_out);
                    errors++;
                end
                if (got.commands_valid !== want.commands_valid) begin
                    $error("commands_valid exp %0d got %0d", want.commands_valid,
                           got.commands_valid);
                    errors++;
                end
                if (got.row_command !== want.row_command) begin
                    $error("row_command exp %h got %h", want.row_command, got.row_command);
                    errors++;
                end
                if (got.column_command !== want.column_command) begin
                    $error("column_command exp %h got %h", want.column_command,
                           got.column_command);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls
    initial begin
        int g;
        forever begin
            @(negedge aclk);
            if (rx_stall_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                g = gap_len() + 1;
                repeat (g) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(FUNC_READ, 8'h00, 8'h00, 8'h00, 9'd0);
        send_request(FUNC_PUTCHAR, 8'h20, 0, 0, 0);
        send_request(FUNC_PUTCHAR, 8'h7f, 0, 0, 0);
        send_request(FUNC_PUTCHAR, 8'h1f, 0, 0, 0);
        send_request(FUNC_PUTCHAR, 8'h80, 0, 0, 0);
        send_request(FUNC_PUTCHAR, 8'hff, 0, 0, 0);
        send_request(FUNC_READ, 0, 0, 0, 9'd1);
        // right-edge wrap: cell 13 starts at column 78 (> 79 is wrap point)
        send_request(FUNC_PIXON, 0, 8'd0, 8'd80, 0);
        send_request(FUNC_PUTCHAR, 8'h41, 0, 0, 0);
        send_request(FUNC_TEXTPOS, 0, 8'd5, 8'd13, 0);
        send_request(FUNC_PUTCHAR, 8'h42, 0, 0, 0);
        // glyph past end of store is refused
        send_request(FUNC_PIXON, 0, 8'd47, 8'd83, 0);
        send_request(FUNC_PUTCHAR, 8'h43, 0, 0, 0);
        send_request(FUNC_TEXTPOS, 0, 8'd6, 8'd0, 0);
        send_request(FUNC_TEXTPOS, 0, 8'd0, 8'd14, 0);
        send_request(FUNC_TEXTPOS, 0, 8'hff, 8'hff, 0);
        send_request(FUNC_PIXOFF, 0, 8'd47, 8'd83, 0);
        send_request(FUNC_PIXON, 0, 8'd48, 8'd0, 0);
        send_request(FUNC_PIXOFF, 0, 8'd0, 8'd84, 0);
        send_request(FUNC_READ, 0, 0, 0, 9'd503);
        send_request(FUNC_READ, 0, 0, 0, 9'd504);
        send_request(FUNC_READ, 0, 0, 0, 9'd511);
        send_request(3'd6, 8'hff, 8'hff, 8'hff, 9'h1ff);
        send_request(3'd7, 0, 0, 0, 0);
        send_request(FUNC_CLEAR, 0, 0, 0, 0);
    endtask

    task automatic test_drain_pause();
        wait_drained();
        send_request(FUNC_READ, 0, 0, 0, 9'd420, 1'b0);
    endtask

    task automatic test_random(int n);
        logic [2:0] f;
        int p;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(0, 99);
            if (p < 2) f = FUNC_CLEAR;
            else if (p < 35) f = FUNC_PUTCHAR;
            else if (p < 45) f = FUNC_TEXTPOS;
            else if (p < 62) f = FUNC_PIXON;
            else if (p < 72) f = FUNC_PIXOFF;
            else if (p < 97) f = FUNC_READ;
            else f = 3'($urandom_range(6, 7));
            // mostly in-range coordinates, with full-range noise
            send_request(f,
                ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(32, 127)),
                ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                    (f == FUNC_TEXTPOS ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 47))),
                ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                    (f == FUNC_TEXTPOS ? 8'($urandom_range(0, 13)) : 8'($urandom_range(0, 83))),
                ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 503)));
            if (i == n / 2) rx_stall_on = 1'b0;
            if (i == 3 * n / 4) rx_stall_on = 1'b1;
        end
    endtask

    initial begin
        for (int i = 0; i < STORE; i++) shadow_store[i] = 8'h00;
        shadow_cursor = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_drain_pause();
        test_random(430);
        wait_drained();
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
